/* design/mqtt5p_pkg.sv */
`timescale 1ns / 1ps

package mqtt5p_pkg;

    localparam int MAX_CAPACITY_DEF = 256;
    localparam int MAX_PROPS_RESET  = 256;
    localparam int QDEPTH           = 4;

    localparam logic [2:0] PH_SECLEN = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_FIXED  = 3'd2;
    localparam logic [2:0] PH_SUBVBI = 3'd3;
    localparam logic [2:0] PH_LENHI  = 3'd4;
    localparam logic [2:0] PH_LENLO  = 3'd5;
    localparam logic [2:0] PH_DATA   = 3'd6;
    localparam logic [2:0] PH_SKIP   = 3'd7;

    localparam logic [2:0] KIND_INT  = 3'd0;
    localparam logic [2:0] KIND_LEN  = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_DONE = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_VBI     = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN = 3'd2;
    localparam logic [2:0] ERR_FULL    = 3'd3;
    localparam logic [2:0] ERR_TRUNC   = 3'd4;

    localparam logic [2:0] CLS_UNKNOWN = 3'd0;
    localparam logic [2:0] CLS_BYTE    = 3'd1;
    localparam logic [2:0] CLS_TWO     = 3'd2;
    localparam logic [2:0] CLS_FOUR    = 3'd3;
    localparam logic [2:0] CLS_VBI     = 3'd4;
    localparam logic [2:0] CLS_STRING  = 3'd5;
    localparam logic [2:0] CLS_USER    = 3'd6;

    localparam logic REG_MAX_PROPS = 1'b0;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  id;
        logic [31:0] value;
        logic        part;
        logic [7:0]  data;
        logic [2:0]  err;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] n;
        rec_t       rec_a;
        rec_t       rec_b;
    } push_t;

    function automatic rec_t make_rec(
        input logic [2:0]  kind,
        input logic [7:0]  id,
        input logic [31:0] value,
        input logic        part,
        input logic [7:0]  data,
        input logic [2:0]  err
    );
        rec_t r;
        r.kind  = kind;
        r.id    = id;
        r.value = value;
        r.part  = part;
        r.data  = data;
        r.err   = err;
        r.last  = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] classify(input logic [7:0] id);
        logic [2:0] c;
        unique case (id) inside
            8'h01, 8'h17, 8'h19, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A: c = CLS_BYTE;
            8'h13, 8'h21, 8'h22, 8'h23:                             c = CLS_TWO;
            8'h02, 8'h11, 8'h18, 8'h27:                             c = CLS_FOUR;
            8'h0B:                                                  c = CLS_VBI;
            8'h03, 8'h08, 8'h12, 8'h15, 8'h1A, 8'h1C, 8'h1F,
            8'h09, 8'h16:                                           c = CLS_STRING;
            8'h26:                                                  c = CLS_USER;
            default:                                                c = CLS_UNKNOWN;
        endcase
        return c;
    endfunction

endpackage

/* design/mqtt5_property_stream_parser_core.sv */
`timescale 1ns / 1ps

// MQTT 5 property section parser, one section byte per input transfer (s_tlast marks the
// buffer's last byte). A byte is taken in the cycle it is offered, one per clock, and its
// records appear on the master side from the next cycle through a four-entry record queue;
// s_tready drops only while that queue has fewer than two free entries. A byte yields at
// most two records, so a stream rich in two-record bytes is paced by the output port at one
// record per cycle. max_properties (byte address 0) is capped at MAX_CAPACITY and should only
// be written while no section is in progress.
module mqtt5_property_stream_parser_core #(
    parameter int MAX_CAPACITY = mqtt5p_pkg::MAX_CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] prop_id, [39:8] value, [47:40] data_byte,
                                   // [50:48] error_code, [55:51] zero
    output logic [3:0]  m_tuser,   // [2:0] record_kind, [3] field_part
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              accept;
    logic [8:0]        max_props;
    mqtt5p_pkg::push_t push;
    mqtt5p_pkg::rec_t  head;

    assign accept = s_tvalid && s_tready;

    mqtt5p_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_props (max_props)
    );

    mqtt5p_parser #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_tdata),
        .buffer_end (s_tlast),
        .max_props  (max_props),
        .push       (push)
    );

    mqtt5p_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (head)
    );

    assign m_tdata = {5'd0, head.err, head.data, head.value, head.id};
    assign m_tuser = {head.part, head.kind};
    assign m_tlast = head.last;

endmodule

/* design/mqtt5p_cfg.sv */
`timescale 1ns / 1ps

module mqtt5p_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [8:0]  max_props
);

    logic [8:0] max_props_reg;
    logic       wr_en;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign max_props = max_props_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_props_reg <= 9'(mqtt5p_pkg::MAX_PROPS_RESET);
        end
        else if (wr_en && paddr[2] == mqtt5p_pkg::REG_MAX_PROPS)
        begin
            max_props_reg <= pwdata[8:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mqtt5p_pkg::REG_MAX_PROPS: prdata = {23'd0, max_props_reg};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

/* design/mqtt5p_parser.sv */
`timescale 1ns / 1ps

module mqtt5p_parser #(
    parameter int MAX_CAPACITY = mqtt5p_pkg::MAX_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              buffer_end,
    input  logic [8:0]        max_props,
    output mqtt5p_pkg::push_t push
);

    localparam int          CAP_CLIP  = (MAX_CAPACITY > 511) ? 511 : MAX_CAPACITY;
    localparam logic [8:0]  CAP       = 9'(CAP_CLIP);
    localparam logic [28:0] CONS_MAX  = '1;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] left_reg, left_next;
    logic [2:0]  vcnt_reg, vcnt_next;
    logic [27:0] decl_reg, decl_next;
    logic [28:0] cons_reg, cons_next;
    logic [8:0]  pcount_reg, pcount_next;
    logic        ufp_reg, ufp_next;

    mqtt5p_pkg::rec_t prim, tail;
    logic        prim_v, tail_v, call_field, call_prop, restart;
    logic [31:0] vbi_acc;
    logic [2:0]  vcnt_inc, cls;
    logic [8:0]  limit;
    logic [15:0] left_dec, len_val;

    assign vbi_acc  = acc_reg | (32'({25'd0, in_byte[6:0]}) << (5'd7 * {3'd0, vcnt_reg[1:0]}));
    assign vcnt_inc = vcnt_reg + 3'd1;
    assign cls      = mqtt5p_pkg::classify(in_byte);
    assign limit    = (CAP < max_props) ? CAP : max_props;
    assign left_dec = left_reg - 16'd1;
    assign len_val  = {acc_reg[7:0], in_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        cur_id_next = cur_id_reg;
        acc_next    = acc_reg;
        left_next   = left_reg;
        vcnt_next   = vcnt_reg;
        decl_next   = decl_reg;
        cons_next   = cons_reg;
        pcount_next = pcount_reg;
        ufp_next    = ufp_reg;
        prim        = '0;
        tail        = '0;
        prim_v      = 1'b0;
        tail_v      = 1'b0;
        call_field  = 1'b0;
        call_prop   = 1'b0;
        restart     = 1'b0;

        if (phase_reg != mqtt5p_pkg::PH_SECLEN && phase_reg != mqtt5p_pkg::PH_SKIP &&
            cons_reg != CONS_MAX)
        begin
            cons_next = cons_reg + 29'd1;
        end

        unique case (phase_reg) inside
            mqtt5p_pkg::PH_SECLEN, mqtt5p_pkg::PH_SUBVBI:
            begin
                acc_next  = vbi_acc;
                vcnt_next = vcnt_inc;
                if (in_byte[7])
                begin
                    if (vcnt_inc >= 3'd4)
                    begin
                        tail_v = 1'b1;
                        tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR,
                            (phase_reg == mqtt5p_pkg::PH_SECLEN) ? 8'd0 : cur_id_reg,
                            32'd0, 1'b0, 8'd0, mqtt5p_pkg::ERR_VBI);
                    end
                    else if (buffer_end)
                    begin
                        tail_v = 1'b1;
                        tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR,
                            (phase_reg == mqtt5p_pkg::PH_SECLEN) ? 8'd0 : cur_id_reg,
                            32'd0, 1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                    end
                end
                else if (phase_reg == mqtt5p_pkg::PH_SECLEN)
                begin
                    decl_next = vbi_acc[27:0];
                    acc_next  = 32'd0;
                    vcnt_next = 3'd0;
                    call_prop = 1'b1;
                end
                else
                begin
                    prim_v    = 1'b1;
                    prim      = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_INT, cur_id_reg, vbi_acc,
                        1'b0, 8'd0, mqtt5p_pkg::ERR_NONE);
                    call_prop = 1'b1;
                end
            end
            mqtt5p_pkg::PH_ID:
            begin
                cur_id_next = in_byte;
                if (cls == mqtt5p_pkg::CLS_UNKNOWN)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, in_byte, 32'd0, 1'b0,
                        8'd0, mqtt5p_pkg::ERR_UNKNOWN);
                end
                else if (pcount_reg >= limit)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, in_byte, 32'd0, 1'b0,
                        8'd0, mqtt5p_pkg::ERR_FULL);
                end
                else
                begin
                    pcount_next = pcount_reg + 9'd1;
                    acc_next    = 32'd0;
                    vcnt_next   = 3'd0;
                    ufp_next    = 1'b0;
                    case (cls)
                        mqtt5p_pkg::CLS_BYTE:
                        begin
                            left_next  = 16'd1;
                            phase_next = mqtt5p_pkg::PH_FIXED;
                        end
                        mqtt5p_pkg::CLS_TWO:
                        begin
                            left_next  = 16'd2;
                            phase_next = mqtt5p_pkg::PH_FIXED;
                        end
                        mqtt5p_pkg::CLS_FOUR:
                        begin
                            left_next  = 16'd4;
                            phase_next = mqtt5p_pkg::PH_FIXED;
                        end
                        mqtt5p_pkg::CLS_VBI: phase_next = mqtt5p_pkg::PH_SUBVBI;
                        default:             phase_next = mqtt5p_pkg::PH_LENHI;
                    endcase
                    if (buffer_end)
                    begin
                        tail_v = 1'b1;
                        tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, in_byte, 32'd0,
                            1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                    end
                end
            end
            mqtt5p_pkg::PH_FIXED:
            begin
                acc_next  = {acc_reg[23:0], in_byte};
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    prim_v    = 1'b1;
                    prim      = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_INT, cur_id_reg,
                        {acc_reg[23:0], in_byte}, 1'b0, 8'd0, mqtt5p_pkg::ERR_NONE);
                    call_prop = 1'b1;
                end
                else if (buffer_end)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, cur_id_reg, 32'd0,
                        1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                end
            end
            mqtt5p_pkg::PH_LENHI:
            begin
                acc_next   = {24'd0, in_byte};
                phase_next = mqtt5p_pkg::PH_LENLO;
                if (buffer_end)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, cur_id_reg, 32'd0,
                        1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                end
            end
            mqtt5p_pkg::PH_LENLO:
            begin
                left_next = len_val;
                prim_v    = 1'b1;
                prim      = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_LEN, cur_id_reg,
                    {16'd0, len_val}, ufp_reg, 8'd0, mqtt5p_pkg::ERR_NONE);
                if (len_val == 16'd0)
                begin
                    call_field = 1'b1;
                end
                else
                begin
                    phase_next = mqtt5p_pkg::PH_DATA;
                    if (buffer_end)
                    begin
                        tail_v = 1'b1;
                        tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, cur_id_reg, 32'd0,
                            1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                    end
                end
            end
            mqtt5p_pkg::PH_DATA:
            begin
                prim_v    = 1'b1;
                prim      = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_DATA, cur_id_reg, 32'd0,
                    ufp_reg, in_byte, mqtt5p_pkg::ERR_NONE);
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    call_field = 1'b1;
                end
                else if (buffer_end)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, cur_id_reg, 32'd0,
                        1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                end
            end
            default:
            begin
                restart = buffer_end;
            end
        endcase

        // user property: key done, value field follows
        if (call_field)
        begin
            if (mqtt5p_pkg::classify(cur_id_reg) == mqtt5p_pkg::CLS_USER && !ufp_reg)
            begin
                ufp_next   = 1'b1;
                phase_next = mqtt5p_pkg::PH_LENHI;
                if (buffer_end)
                begin
                    tail_v = 1'b1;
                    tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_ERR, cur_id_reg, 32'd0,
                        1'b0, 8'd0, mqtt5p_pkg::ERR_TRUNC);
                end
            end
            else
            begin
                call_prop = 1'b1;
            end
        end

        if (call_prop)
        begin
            if (cons_next >= {1'b0, decl_next} || buffer_end)
            begin
                tail_v = 1'b1;
                tail   = mqtt5p_pkg::make_rec(mqtt5p_pkg::KIND_DONE, 8'd0,
                    {23'd0, pcount_next}, 1'b0, 8'd0, mqtt5p_pkg::ERR_NONE);
            end
            else
            begin
                phase_next = mqtt5p_pkg::PH_ID;
            end
        end

        if (tail_v)
        begin
            if (buffer_end)
            begin
                restart = 1'b1;
            end
            else
            begin
                phase_next = mqtt5p_pkg::PH_SKIP;
            end
        end

        if (restart)
        begin
            phase_next  = mqtt5p_pkg::PH_SECLEN;
            cur_id_next = 8'd0;
            acc_next    = 32'd0;
            left_next   = 16'd0;
            vcnt_next   = 3'd0;
            decl_next   = 28'd0;
            cons_next   = 29'd0;
            pcount_next = 9'd0;
            ufp_next    = 1'b0;
        end
    end

    always_comb
    begin
        push.n     = accept ? ({1'b0, prim_v} + {1'b0, tail_v}) : 2'd0;
        push.rec_a = prim_v ? prim : tail;
        push.rec_b = tail;
        push.rec_a.last = !(prim_v && tail_v);
        push.rec_b.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mqtt5p_pkg::PH_SECLEN;
            cur_id_reg <= 8'd0;
            acc_reg    <= 32'd0;
            left_reg   <= 16'd0;
            vcnt_reg   <= 3'd0;
            decl_reg   <= 28'd0;
            cons_reg   <= 29'd0;
            pcount_reg <= 9'd0;
            ufp_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            cur_id_reg <= cur_id_next;
            acc_reg    <= acc_next;
            left_reg   <= left_next;
            vcnt_reg   <= vcnt_next;
            decl_reg   <= decl_next;
            cons_reg   <= cons_next;
            pcount_reg <= pcount_next;
            ufp_reg    <= ufp_next;
        end
    end

    // every section ends when the buffer ends
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && buffer_end |=> phase_reg == mqtt5p_pkg::PH_SECLEN)
        else $error("buffer end did not restart the section");

    a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        accept && buffer_end && phase_reg != mqtt5p_pkg::PH_SKIP |-> push.n != 2'd0)
        else $error("buffer end inside a section gave no closing record");

endmodule

/* design/mqtt5p_out_queue.sv */
`timescale 1ns / 1ps

module mqtt5p_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  mqtt5p_pkg::push_t push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output mqtt5p_pkg::rec_t  out_rec
);

    localparam int DEPTH = mqtt5p_pkg::QDEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    mqtt5p_pkg::rec_t q_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_rec   = q_reg[rptr_reg];
    assign room      = count_reg <= CNT_W'(DEPTH - 2);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(push.n);
        rptr_next  = rptr_reg + PTR_W'(pop);
        count_next = count_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            q_reg[wptr_reg] <= push.rec_a;
        end
        if (push.n == 2'd2)
        begin
            q_reg[wptr_reg + PTR_W'(1)] <= push.rec_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(push.n) + count_reg <= CNT_W'(DEPTH) + CNT_W'(pop))
        else $error("record queue overflow");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push.n == 2'd0 |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("record queue count lost track of a transfer");

endmodule
